### hdl/tie_pkg.sv
// ----------------------------------------------------------------------------
// tie_pkg
// Shared types and constants for the trap and interrupt entry unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tie_pkg;

	localparam int XLEN        = 64;
	localparam int CAUSE_W     = 4;
	localparam int IRQ_W       = 12;
	localparam int EXC_DELEG_W = 16;
	localparam int STATUS_W    = 13;
	localparam int PRIV_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int VEC_SHIFT   = 2;   // vectored entries are four bytes apart

	typedef enum logic [1:0] {
		ACT_RAISE = 2'd0,
		ACT_IRQ   = 2'd1,
		ACT_LOAD  = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXC_DELEG = 2'd0,
		CFG_IRQ_DELEG = 2'd1,
		CFG_MTVEC     = 2'd2,
		CFG_STVEC     = 2'd3
	} cfg_idx_t;

	localparam logic [PRIV_W-1:0] PRIV_U = 2'd0;
	localparam logic [PRIV_W-1:0] PRIV_S = 2'd1;
	localparam logic [PRIV_W-1:0] PRIV_M = 2'd3;

	localparam logic [1:0] MODE_VECTORED = 2'd1;

	// status bit positions
	localparam int ST_SIE  = 1;
	localparam int ST_MIE  = 3;
	localparam int ST_SPIE = 5;
	localparam int ST_MPIE = 7;
	localparam int ST_SPP  = 8;
	localparam int ST_MPP  = 11;

	// interrupt priority, highest first: MEI, MSI, MTI, SEI, SSI, STI
	localparam int IRQ_SCAN_N = 6;
	localparam logic [CAUSE_W-1:0] IRQ_SCAN [IRQ_SCAN_N] =
		'{4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5};

	typedef struct packed {
		action_t             action;
		logic [CAUSE_W-1:0]  cause_code;
		logic [XLEN-1:0]     trap_value;
		logic [XLEN-1:0]     current_pc;
		logic [IRQ_W-1:0]    irq_pending;
		logic [IRQ_W-1:0]    irq_enable;
		logic [STATUS_W-1:0] status_load;
		logic [PRIV_W-1:0]   priv_load;
	} req_t;

	typedef struct packed {
		logic                trap_taken;
		logic [XLEN-1:0]     next_pc;
		logic [XLEN-1:0]     cause_written;
		logic                to_supervisor;
		logic                any_enabled_pending;
		logic [STATUS_W-1:0] status_now;
		logic [PRIV_W-1:0]   priv_now;
		logic [XLEN-1:0]     saved_pc;
		logic [XLEN-1:0]     saved_value;
	} rsp_t;

endpackage

`default_nettype wire

### hdl/tie_ifs.sv
// ----------------------------------------------------------------------------
// tie_ifs
// Valid/ready channels for trap entry requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tie_req_if;
	logic          valid;
	logic          ready;
	tie_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tie_rsp_if;
	logic          valid;
	logic          ready;
	tie_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/trap_and_interrupt_entry_top.sv
// ----------------------------------------------------------------------------
// trap_and_interrupt_entry_top
// Trap entry with delegation: exceptions, interrupt selection, priv/status load.
// ----------------------------------------------------------------------------
// One request per cycle is sustained while the result side is not stalled. A
// request lands in the input register at the edge that accepts it and is
// resolved against the current privilege and status in one pass of shallow
// logic. Its result is captured in and presented from the output register,
// and privilege and status update at that same edge. That privilege/status
// feedback loop, a single register level, is what sets the one-request-per-
// cycle rate. If the result side stalls, ready drops once the input register
// holds a request; it takes one more request only if it was empty.
// Configuration writes (delegation masks, trap vectors) are expected only
// while the unit is idle. The epc/cause/tval values that a trap writes into
// its bank are reported on that result as saved_pc, cause_written and
// saved_value, and are zero when no trap is taken; nothing reads the banks
// back, so they are not kept.
// ----------------------------------------------------------------------------
`default_nettype none

module trap_and_interrupt_entry_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tie_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tie_pkg::XLEN-1:0]        cfg_data,
	tie_req_if.sink                              req,
	tie_rsp_if.source                            rsp
);

	// configuration
	logic [tie_pkg::EXC_DELEG_W-1:0] exc_deleg_q;
	logic [tie_pkg::IRQ_W-1:0]       irq_deleg_q;
	logic [tie_pkg::XLEN-1:0]        mtvec_q;
	logic [tie_pkg::XLEN-1:0]        stvec_q;

	// architectural state
	logic [tie_pkg::STATUS_W-1:0]    status_q;
	logic [tie_pkg::PRIV_W-1:0]      priv_q;

	// pipeline
	logic          valid_s1;
	tie_pkg::req_t req_s1;
	logic          valid_s2;
	tie_pkg::rsp_t rsp_s2;

	logic move_s1;
	logic req_fire;

	// resolve
	logic [tie_pkg::IRQ_W-1:0]       pend;
	logic                            m_en;
	logic                            s_en;
	logic                            irq_hit;
	logic [tie_pkg::CAUSE_W-1:0]     irq_sel;
	logic                            take;
	logic                            is_irq;
	logic                            load;
	logic [tie_pkg::CAUSE_W-1:0]     cause;
	logic [tie_pkg::EXC_DELEG_W-1:0] irq_deleg_ext;
	logic                            deleg_bit;
	logic                            to_s;
	logic [tie_pkg::XLEN-1:0]        vec;
	logic [tie_pkg::XLEN-1:0]        base;
	logic [tie_pkg::XLEN-1:0]        target;
	logic [tie_pkg::STATUS_W-1:0]    status_n;
	logic [tie_pkg::PRIV_W-1:0]      priv_n;
	tie_pkg::rsp_t                   rsp_n;

	assign move_s1   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || move_s1;
	assign req_fire  = req.valid && req.ready;

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exc_deleg_q <= '0;
			irq_deleg_q <= '0;
			mtvec_q     <= '0;
			stvec_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tie_pkg::CFG_EXC_DELEG: exc_deleg_q <= cfg_data[tie_pkg::EXC_DELEG_W-1:0];
				tie_pkg::CFG_IRQ_DELEG: irq_deleg_q <= cfg_data[tie_pkg::IRQ_W-1:0];
				tie_pkg::CFG_MTVEC:     mtvec_q     <= cfg_data;
				tie_pkg::CFG_STVEC:     stvec_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// interrupt eligibility at the current privilege
	always_comb begin
		pend    = req_s1.irq_pending & req_s1.irq_enable;
		m_en    = (priv_q != tie_pkg::PRIV_M) || status_q[tie_pkg::ST_MIE];
		s_en    = (priv_q == tie_pkg::PRIV_U) ||
		          ((priv_q == tie_pkg::PRIV_S) && status_q[tie_pkg::ST_SIE]);
		irq_hit = 1'b0;
		irq_sel = '0;
		// walk lowest priority first so the highest eligible line wins
		for (int i = tie_pkg::IRQ_SCAN_N - 1; i >= 0; i--) begin
			if (pend[tie_pkg::IRQ_SCAN[i]] &&
			    (irq_deleg_q[tie_pkg::IRQ_SCAN[i]] ? s_en : m_en)) begin
				irq_hit = 1'b1;
				irq_sel = tie_pkg::IRQ_SCAN[i];
			end
		end
	end

	// trap decision and state update
	always_comb begin
		take   = 1'b0;
		is_irq = 1'b0;
		load   = 1'b0;
		cause  = req_s1.cause_code;
		case (req_s1.action)
			tie_pkg::ACT_RAISE: begin
				take = 1'b1;
			end
			tie_pkg::ACT_IRQ: begin
				take   = irq_hit;
				is_irq = 1'b1;
				cause  = irq_sel;
			end
			tie_pkg::ACT_LOAD: begin
				load = 1'b1;
			end
			default: ;
		endcase

		irq_deleg_ext = {{(tie_pkg::EXC_DELEG_W - tie_pkg::IRQ_W){1'b0}}, irq_deleg_q};
		deleg_bit     = is_irq ? irq_deleg_ext[cause] : exc_deleg_q[cause];
		// delegation only from U or S; reserved priv 2 stays in M
		to_s = take && deleg_bit &&
		       ((priv_q == tie_pkg::PRIV_U) || (priv_q == tie_pkg::PRIV_S));

		vec  = to_s ? stvec_q : mtvec_q;
		base = {vec[tie_pkg::XLEN-1:2], 2'b00};
		if ((vec[1:0] == tie_pkg::MODE_VECTORED) && is_irq) begin
			target = base + {{(tie_pkg::XLEN - tie_pkg::CAUSE_W - tie_pkg::VEC_SHIFT){1'b0}},
			                 cause, {tie_pkg::VEC_SHIFT{1'b0}}};
		end else begin
			target = base;
		end

		status_n = status_q;
		priv_n   = priv_q;
		if (take) begin
			if (to_s) begin
				status_n[tie_pkg::ST_SPIE] = status_q[tie_pkg::ST_SIE];
				status_n[tie_pkg::ST_SIE]  = 1'b0;
				status_n[tie_pkg::ST_SPP]  = priv_q[0];
				priv_n                     = tie_pkg::PRIV_S;
			end else begin
				status_n[tie_pkg::ST_MPIE]           = status_q[tie_pkg::ST_MIE];
				status_n[tie_pkg::ST_MIE]            = 1'b0;
				status_n[tie_pkg::ST_MPP +: tie_pkg::PRIV_W] = priv_q;
				priv_n                               = tie_pkg::PRIV_M;
			end
		end else if (load) begin
			status_n = req_s1.status_load;
			priv_n   = req_s1.priv_load;
		end

		rsp_n.trap_taken          = take;
		rsp_n.next_pc             = take ? target : '0;
		rsp_n.cause_written       = '0;
		if (take) begin
			rsp_n.cause_written = {is_irq,
			                       {(tie_pkg::XLEN - 1 - tie_pkg::CAUSE_W){1'b0}}, cause};
		end
		rsp_n.to_supervisor       = to_s;
		rsp_n.any_enabled_pending = |pend;
		rsp_n.status_now          = status_n;
		rsp_n.priv_now            = priv_n;
		rsp_n.saved_pc            = take ? req_s1.current_pc : '0;
		// interrupts record tval zero
		rsp_n.saved_value         = (take && !is_irq) ? req_s1.trap_value : '0;
	end

	// state and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			priv_q   <= tie_pkg::PRIV_M;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (move_s1) begin
				status_q <= status_n;
				priv_q   <= priv_n;
			end
			if (req_fire) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req.data;
		end
		if (move_s1) begin
			rsp_s2 <= rsp_n;
		end
	end

endmodule

`default_nettype wire

### hdl/tie_checker.sv
// ----------------------------------------------------------------------------
// tie_checker
// Port-level checks on trap entry results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tie_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire tie_pkg::rsp_t rsp_data
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// no trap: trap fields are all zero
	a_no_trap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.trap_taken |->
			rsp_data.next_pc == '0 && rsp_data.cause_written == '0 &&
			!rsp_data.to_supervisor && rsp_data.saved_pc == '0 &&
			rsp_data.saved_value == '0)
		else $error("trap fields set without a trap");

	// S-mode trap lands in S with SIE cleared
	a_s_trap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.to_supervisor |->
			rsp_data.trap_taken && rsp_data.priv_now == tie_pkg::PRIV_S &&
			!rsp_data.status_now[tie_pkg::ST_SIE])
		else $error("supervisor trap state wrong");

	// M-mode trap lands in M with MIE cleared
	a_m_trap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.trap_taken && !rsp_data.to_supervisor |->
			rsp_data.priv_now == tie_pkg::PRIV_M &&
			!rsp_data.status_now[tie_pkg::ST_MIE])
		else $error("machine trap state wrong");

	// interrupts record zero tval and need a pending enabled line
	a_irq_tval: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.cause_written[tie_pkg::XLEN-1] |->
			rsp_data.saved_value == '0 && rsp_data.any_enabled_pending)
		else $error("interrupt trap inconsistent");

endmodule

bind trap_and_interrupt_entry_top tie_checker u_tie_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
